// File: rtl/core/sorted_priority_queue_defines.svh
// Assertion macros used by the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Implication that holds in the same cycle, checked while out of reset
`define SPQ_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// Implication that holds in the following cycle, checked while out of reset
`define SPQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// Types and codes shared by the sorted priority queue modules
package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned OccW   = 5;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StRemoved  = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } spq_status_e;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_in;   // insert: open a slot and take the new entry
    logic shift_out;  // remove: advance every entry towards the front
  } spq_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
  } spq_entry_t;

endpackage

// File: rtl/core/sorted_priority_queue.sv
// Sorted priority queue built from a chain of compare-and-shift cells
//
//   channel  | dir | tdata (low bit up)                               | tuser
//   s_axis   | in  | item_value[31:0], item_priority[47:32]           | op[0]
//   m_axis   | out | out_value[31:0], out_priority[47:32],            | status[1:0]
//            |     | occupancy[52:48], zero fill [55:53]              |
//
// One item is taken per cycle unless the output stalls; its result appears in the output
// register the next cycle. Every cell compares its priority with the new one in parallel,
// so an insert or a remove updates the whole chain at once, whatever the occupancy.
// Reset empties the chain at once by clearing the cell valid flags and the count.
// s_axis_tready follows the output register: a new transfer is taken while the held
// result is free or is being taken in the same cycle.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // item_value[31:0], item_priority[47:32]
  input  logic [0:0]  s_axis_tuser,  // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_value[31:0], out_priority[47:32], occupancy[52:48]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  spq_ctrl_t   ctrl;
  spq_entry_t  new_entry;
  spq_entry_t  idle_entry;
  spq_entry_t  cell_entry [CAPACITY];
  logic        cell_gt    [CAPACITY];

  logic            accept;
  logic            is_remove;
  logic            full;
  logic            empty;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW+4:0] count_ext;
  spq_status_e     status;

  logic              out_valid_q;
  spq_status_e       out_status_q;
  logic [ValueW-1:0] out_value_q;
  logic [PrioW-1:0]  out_prio_q;
  logic [OccW-1:0]   out_occ_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_remove     = (s_axis_tuser[0] == OpRemove);
  assign full          = (count_q == CntW'(CAPACITY));
  assign empty         = (count_q == '0);

  assign ctrl.shift_in  = accept && !is_remove && !full;
  assign ctrl.shift_out = accept && is_remove && !empty;

  assign new_entry.valid = 1'b1;
  assign new_entry.value = s_axis_tdata[31:0];
  assign new_entry.prio  = s_axis_tdata[47:32];

  assign idle_entry.valid = 1'b0;
  assign idle_entry.value = '0;
  assign idle_entry.prio  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .prev_i    ((i == 0) ? idle_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .next_i    ((i == CAPACITY - 1) ? idle_entry
                                      : cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
      .prev_gt_i ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .entry_o   (cell_entry[i]),
      .gt_o      (cell_gt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.shift_in) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.shift_out) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    if (is_remove) begin
      status = empty ? StEmpty : StRemoved;
    end else begin
      status = full ? StFull : StInserted;
    end
  end

  // Occupancy field keeps only its low five bits
  assign count_ext = {5'd0, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= status;
      out_occ_q    <= count_ext[OccW-1:0];
      if (ctrl.shift_out) begin
        out_value_q <= cell_entry[0].value;
        out_prio_q  <= cell_entry[0].prio;
      end else begin
        out_value_q <= '0;
        out_prio_q  <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_prio_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// File: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbours
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spq_ctrl_t  ctrl_i,
  input  spq_entry_t new_i,     // entry being inserted
  input  spq_entry_t prev_i,    // neighbour nearer the front
  input  spq_entry_t next_i,    // neighbour nearer the back
  input  logic       prev_gt_i, // neighbour nearer the front sits behind the new entry
  output spq_entry_t entry_o,
  output logic       gt_o
);

  logic              valid_q, valid_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [PrioW-1:0]  prio_q, prio_d;

  // An empty slot counts as behind any new entry; equal priority stays in front
  assign gt_o = !valid_q || (prio_q > new_i.prio);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.shift_in) begin
      if (prev_gt_i) begin
        valid_d = prev_i.valid;
        value_d = prev_i.value;
        prio_d  = prev_i.prio;
      end else if (gt_o) begin
        valid_d = 1'b1;
        value_d = new_i.value;
        prio_d  = new_i.prio;
      end
    end else if (ctrl_i.shift_out) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
      prio_d  = next_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.value = value_q;
  assign entry_o.prio  = prio_q;

endmodule

// File: rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level
`include "sorted_priority_queue_defines.svh"

module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  localparam logic [OccW-1:0] CapLow = OccW'(CAPACITY % 32);

  logic out_empty;
  logic out_full;
  logic out_inserted;
  logic out_zero_payload;

  assign out_empty        = m_axis_tvalid && (m_axis_tuser == StEmpty);
  assign out_full         = m_axis_tvalid && (m_axis_tuser == StFull);
  assign out_inserted     = m_axis_tvalid && (m_axis_tuser == StInserted);
  assign out_zero_payload = (m_axis_tdata[47:0] == 48'd0);

  // A stalled result keeps its contents
  `SPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `SPQ_ASSERT_NOW(a_empty_report, out_empty,
    out_zero_payload && (m_axis_tdata[52:48] == 5'd0), "empty report with entries or data")

  `SPQ_ASSERT_NOW(a_full_report, out_full,
    out_zero_payload && (m_axis_tdata[52:48] == CapLow), "full report at wrong occupancy")

  `SPQ_ASSERT_NOW(a_insert_payload, out_inserted,
    out_zero_payload && (m_axis_tdata[52:48] != 5'd0), "insert result carries data")

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the sorted priority queue
module tb_top;
  import spq_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned RandomItems = 1030;
  localparam int unsigned IdleLimit   = 2000;

  typedef struct {
    spq_status_e       status;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
    logic [OccW-1:0]   occ;
  } result_t;

  typedef struct {
    logic              op;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // item_value[31:0], item_priority[47:32]
  logic [0:0]  s_axis_tuser;   // op[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // out_value[31:0], out_priority[47:32], occupancy[52:48]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  // Shadow copy of the queue contents, front entry at index 0
  logic [ValueW-1:0] shadow_value [Capacity];
  logic [PrioW-1:0]  shadow_prio  [Capacity];
  int unsigned       shadow_count;

  result_t     pending_results[$];
  stim_row_t   stim_rows[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          send_steady;
  bit          recv_steady;

  sorted_priority_queue #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Insert behind every entry of equal or smaller priority number; remove from the front
  function automatic result_t sorted_list_apply(input logic op, input logic [ValueW-1:0] val,
                                                input logic [PrioW-1:0] prio);
    result_t     res;
    int unsigned pos;
    res.status = StInserted;
    res.value  = '0;
    res.prio   = '0;
    if (op == OpInsert) begin
      if (shadow_count >= Capacity) begin
        res.status = StFull;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
        for (int unsigned i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = val;
        shadow_prio[pos]  = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = StEmpty;
    end else begin
      res.status = StRemoved;
      res.value  = shadow_value[0];
      res.prio   = shadow_prio[0];
      for (int unsigned i = 1; i < shadow_count; i++) begin
        shadow_value[i-1] = shadow_value[i];
        shadow_prio[i-1]  = shadow_prio[i];
      end
      shadow_count--;
    end
    res.occ = OccW'(shadow_count);
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_row(input logic op, input logic [ValueW-1:0] val,
                                  input logic [PrioW-1:0] prio, input bit typed,
                                  input spq_status_e st, input logic [ValueW-1:0] rv,
                                  input logic [PrioW-1:0] rp, input logic [OccW-1:0] occ);
    stim_row_t row;
    row.op          = op;
    row.value       = val;
    row.prio        = prio;
    row.typed       = typed;
    row.want.status = st;
    row.want.value  = rv;
    row.want.prio   = rp;
    row.want.occ    = occ;
    stim_rows.push_back(row);
  endfunction

  task automatic transfer_item(input logic op, input logic [ValueW-1:0] val,
                               input logic [PrioW-1:0] prio, input bit typed,
                               input result_t want);
    result_t got;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, val};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = sorted_list_apply(op, val, prio);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = pick_gap(send_steady);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Receiver: random back-pressure with stretches of none
  initial begin : receiver
    int unsigned stall_left;
    stall_left    = 0;
    recv_steady   = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 299) == 0) recv_steady = ~recv_steady;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap(recv_steady);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d tdata %h", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[31:0] !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[47:32] !== want.prio) begin
          $error("out_priority: expected %h, got %h", want.prio, m_axis_tdata[47:32]);
          fail_count++;
        end
        if (m_axis_tdata[52:48] !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, m_axis_tdata[52:48]);
          fail_count++;
        end
        if (m_axis_tdata[55:53] !== 3'b000) begin
          $error("zero fill: expected 0, got %0d", m_axis_tdata[55:53]);
          fail_count++;
        end
      end
    end
  end

  // Count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic              op;
    logic [ValueW-1:0] val;
    logic [PrioW-1:0]  prio;
    bit                drain_mode;
    int unsigned       r;
    result_t           unused;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OpInsert;
    shadow_count  = 0;
    send_steady   = 1'b0;
    drain_mode    = 1'b0;
    unused.status = StInserted;
    unused.value  = '0;
    unused.prio   = '0;
    unused.occ    = '0;

    // Directed part: empty remove, extremes, ties, fill to full, then tie order
    add_row(OpRemove, 32'h0, 16'h0, 1'b1, StEmpty, 32'h0, 16'h0, 5'd0);
    add_row(OpInsert, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, StInserted, 32'h0, 16'h0, 5'd1);
    add_row(OpInsert, 32'h8000_0000, 16'h0000, 1'b1, StInserted, 32'h0, 16'h0, 5'd2);
    add_row(OpInsert, 32'd1, 16'd5, 1'b0, StInserted, 32'h0, 16'h0, 5'd0);
    add_row(OpInsert, 32'd2, 16'd5, 1'b0, StInserted, 32'h0, 16'h0, 5'd0);
    add_row(OpInsert, 32'd3, 16'd5, 1'b0, StInserted, 32'h0, 16'h0, 5'd0);
    add_row(OpRemove, 32'h0, 16'h0, 1'b1, StRemoved, 32'h8000_0000, 16'h0000, 5'd4);
    for (int unsigned i = 0; i < 12; i++) begin
      add_row(OpInsert, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : 32'hA5A5_0000 | i,
              16'hFFFF, 1'b0, StInserted, 32'h0, 16'h0, 5'd0);
    end
    add_row(OpInsert, 32'h1234_5678, 16'h0001, 1'b1, StFull, 32'h0, 16'h0, 5'd16);
    repeat (3) add_row(OpRemove, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, StRemoved, 32'h0, 16'h0, 5'd0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[k]) begin
      transfer_item(stim_rows[k].op, stim_rows[k].value, stim_rows[k].prio,
                    stim_rows[k].typed, stim_rows[k].want);
      sender_gap();
    end

    // Hold the sender until the directed results have drained
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      if ($urandom_range(0, 59) == 0) send_steady = ~send_steady;
      // Swing between filling and draining so both full and empty are reached
      if (!drain_mode && shadow_count == Capacity && $urandom_range(0, 3) == 0) drain_mode = 1'b1;
      if (drain_mode && shadow_count == 0 && $urandom_range(0, 3) == 0) drain_mode = 1'b0;
      if ($urandom_range(0, 99) < 80) op = drain_mode ? OpRemove : OpInsert;
      else op = drain_mode ? OpInsert : OpRemove;
      r = $urandom_range(0, 9);
      if (r < 4) prio = PrioW'($urandom_range(0, 3));
      else if (r < 6) prio = $urandom_range(0, 1) ? '1 : '0;
      else prio = PrioW'($urandom);
      val = $urandom;
      transfer_item(op, val, prio, 1'b0, unused);
      sender_gap();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
